// File: rtl/core/ssd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Session stream deframer package
// Shared item types, session state layout and protocol codes.
// ----------------------------------------------------------------------------
package ssd_pkg;

    // One received item: a data byte or a connect event.
    typedef struct packed {
        logic       mode;
        logic [7:0] rx_byte;
    } t_in_item;

    // One result item.
    typedef struct packed {
        logic [3:0] event_res;
        logic       retry_legacy;
        logic [7:0] out_byte;
        logic [1:0] stream_id;
        logic       last;
    } t_out_item;

    // Session phases.
    typedef enum logic [6:0] {
        PH_CONNECTING   = 7'b0000001,
        PH_TRANSPORT    = 7'b0000010,
        PH_SHELL        = 7'b0000100,
        PH_FAIL_LENGTH  = 7'b0001000,
        PH_FAIL_MESSAGE = 7'b0010000,
        PH_STREAMING    = 7'b0100000,
        PH_FINISHED     = 7'b1000000
    } t_phase;

    // Session parser state. Only three status bytes are ever held between
    // transfers, since the fourth completes the word and clears it.
    typedef struct packed {
        t_phase      phase;
        logic [2:0]  header_position;
        logic [23:0] status_word;
        logic [7:0]  packet_kind;
        logic [31:0] bytes_remaining;
        logic [15:0] message_remaining;
    } t_state;

    // Mode field values.
    localparam logic MODE_BYTE    = 1'b0;
    localparam logic MODE_CONNECT = 1'b1;

    // Result event codes.
    localparam logic [3:0] EV_PAYLOAD        = 4'd0;
    localparam logic [3:0] EV_SEND_TRANSPORT = 4'd1;
    localparam logic [3:0] EV_SEND_SHELL     = 4'd2;
    localparam logic [3:0] EV_STARTED        = 4'd3;
    localparam logic [3:0] EV_EXITED         = 4'd4;
    localparam logic [3:0] EV_BAD_PACKET     = 4'd5;
    localparam logic [3:0] EV_BAD_RESPONSE   = 4'd6;
    localparam logic [3:0] EV_BAD_ERR_LEN    = 4'd7;
    localparam logic [3:0] EV_FAIL_BYTE      = 4'd8;
    localparam logic [3:0] EV_FAIL_END       = 4'd9;

    // Configuration register indexes.
    localparam logic REG_USE_FRAMED = 1'b0;
    localparam logic REG_MAX_PACKET = 1'b1;

    localparam int unsigned MAX_LEN_W = 25;
    localparam logic [MAX_LEN_W-1:0] DEFAULT_MAX_PACKET = 25'h1000000;

    // Status words, first byte in the high bits.
    localparam logic [31:0] STATUS_OKAY = 32'h4F4B4159;
    localparam logic [31:0] STATUS_FAIL = 32'h4641494C;

    // Packet header length and packet ids.
    localparam logic [2:0] HEADER_BYTES = 3'd5;
    localparam logic [7:0] KIND_STDOUT  = 8'd1;
    localparam logic [7:0] KIND_STDERR  = 8'd2;
    localparam logic [7:0] KIND_EXIT    = 8'd3;

    // Origin of a failure, held in packet_kind while the failure runs.
    localparam logic [7:0] FROM_TRANSPORT = 8'd1;
    localparam logic [7:0] FROM_SHELL     = 8'd2;

endpackage

// File: rtl/core/ssd_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Session stream deframer step logic
// Computes the next session state and up to two results for one item.
// ----------------------------------------------------------------------------
module ssd_step import ssd_pkg::*; (
    input  t_in_item               i_item,
    input  t_state                 i_st,
    input  logic                   i_framed,
    input  logic [MAX_LEN_W-1:0]   i_max_len,
    output t_state                 o_st,
    output logic                   o_framed,
    output t_out_item              o_res0,
    output t_out_item              o_res1,
    output logic [1:0]             o_nres
);

    // Returns {valid, digit} for an ASCII hex character.
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, 4'(c - 8'h30)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r = {1'b1, 4'(c - 8'h37)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            r = {1'b1, 4'(c - 8'h57)};
        end
        return r;
    endfunction

    function automatic t_out_item mk_res(input logic [3:0] ev, input logic retry,
                                         input logic [7:0] data, input logic [1:0] sid);
        t_out_item r;
        r.event_res    = ev;
        r.retry_legacy = retry;
        r.out_byte     = data;
        r.stream_id    = sid;
        r.last         = 1'b0;
        return r;
    endfunction

    logic [7:0]  w_b;
    logic [31:0] w_word;
    logic [4:0]  w_hex;
    logic [15:0] w_msg_shift;
    logic [15:0] w_msg_dec;
    logic [2:0]  w_pos_inc;
    logic [31:0] w_len;
    logic [31:0] w_rem_dec;
    logic        w_retry;
    logic        w_kind_out;

    assign w_b         = i_item.rx_byte;
    assign w_word      = {i_st.status_word, w_b};
    assign w_hex       = hex_digit(w_b);
    assign w_msg_shift = {i_st.message_remaining[11:0], w_hex[3:0]};
    assign w_msg_dec   = i_st.message_remaining - 16'd1;
    assign w_pos_inc   = i_st.header_position + 3'd1;
    assign w_rem_dec   = i_st.bytes_remaining - 32'd1;
    assign w_retry     = (i_st.packet_kind == FROM_SHELL) && i_framed;
    assign w_kind_out  = (i_st.packet_kind == KIND_STDOUT) ||
                         (i_st.packet_kind == KIND_STDERR);

    // Little-endian length assembly; the first header byte is the packet id.
    always_comb begin
        unique case (i_st.header_position)
            3'd1:    w_len = i_st.bytes_remaining | {24'd0, w_b};
            3'd2:    w_len = i_st.bytes_remaining | {16'd0, w_b, 8'd0};
            3'd3:    w_len = i_st.bytes_remaining | {8'd0, w_b, 16'd0};
            3'd4:    w_len = i_st.bytes_remaining | {w_b, 24'd0};
            default: w_len = i_st.bytes_remaining;
        endcase
    end

    always_comb begin
        o_st     = i_st;
        o_framed = i_framed;
        o_res0   = '0;
        o_res1   = '0;
        o_nres   = 2'd0;

        if (i_item.mode == MODE_CONNECT) begin
            // A connect event restarts the handshake unless the session is over.
            if (i_st.phase != PH_FINISHED) begin
                o_st                   = '0;
                o_st.phase             = PH_TRANSPORT;
                o_res0                 = mk_res(EV_SEND_TRANSPORT, 1'b0, 8'd0, 2'd0);
                o_nres                 = 2'd1;
            end
        end else begin
            unique case (i_st.phase)
                PH_TRANSPORT, PH_SHELL: begin
                    if (i_st.header_position != 3'd3) begin
                        o_st.status_word     = w_word[23:0];
                        o_st.header_position = w_pos_inc;
                    end else begin
                        o_st.status_word     = '0;
                        o_st.header_position = 3'd0;
                        if (w_word == STATUS_OKAY) begin
                            o_nres = 2'd1;
                            if (i_st.phase == PH_TRANSPORT) begin
                                o_st.phase = PH_SHELL;
                                o_res0     = mk_res(EV_SEND_SHELL, 1'b0, 8'd0, 2'd0);
                            end else begin
                                o_st.phase = PH_STREAMING;
                                o_res0     = mk_res(EV_STARTED, 1'b0, 8'd0, 2'd0);
                            end
                        end else if (w_word == STATUS_FAIL) begin
                            o_st.packet_kind       = (i_st.phase == PH_TRANSPORT) ?
                                                     FROM_TRANSPORT : FROM_SHELL;
                            o_st.phase             = PH_FAIL_LENGTH;
                            o_st.message_remaining = '0;
                        end else begin
                            o_st.phase = PH_FINISHED;
                            o_res0     = mk_res(EV_BAD_RESPONSE, 1'b0, 8'd0, 2'd0);
                            o_nres     = 2'd1;
                        end
                    end
                end

                PH_FAIL_LENGTH: begin
                    if (!w_hex[4]) begin
                        o_st.phase           = PH_FINISHED;
                        o_st.header_position = 3'd0;
                        o_res0               = mk_res(EV_BAD_ERR_LEN, 1'b0, 8'd0, 2'd0);
                        o_nres               = 2'd1;
                    end else begin
                        o_st.message_remaining = w_msg_shift;
                        o_st.header_position   = w_pos_inc;
                        if (i_st.header_position == 3'd3) begin
                            o_st.header_position = 3'd0;
                            if (w_msg_shift == 16'd0) begin
                                // An empty message ends the failure at once.
                                o_st.packet_kind = '0;
                                o_st.phase       = w_retry ? PH_CONNECTING : PH_FINISHED;
                                o_framed         = i_framed & ~w_retry;
                                o_res0           = mk_res(EV_FAIL_END, w_retry, 8'd0, 2'd0);
                                o_nres           = 2'd1;
                            end else begin
                                o_st.phase = PH_FAIL_MESSAGE;
                            end
                        end
                    end
                end

                PH_FAIL_MESSAGE: begin
                    o_st.message_remaining = w_msg_dec;
                    o_res0                 = mk_res(EV_FAIL_BYTE, 1'b0, w_b, 2'd0);
                    o_nres                 = 2'd1;
                    if (w_msg_dec == 16'd0) begin
                        o_st.header_position = 3'd0;
                        o_st.packet_kind     = '0;
                        o_st.phase           = w_retry ? PH_CONNECTING : PH_FINISHED;
                        o_framed             = i_framed & ~w_retry;
                        o_res1               = mk_res(EV_FAIL_END, w_retry, 8'd0, 2'd0);
                        o_nres               = 2'd2;
                    end
                end

                PH_STREAMING: begin
                    if (!i_framed) begin
                        o_res0 = mk_res(EV_PAYLOAD, 1'b0, w_b, 2'd0);
                        o_nres = 2'd1;
                    end else if (i_st.header_position >= HEADER_BYTES) begin
                        // Inside a payload.
                        if (w_kind_out) begin
                            o_res0 = mk_res(EV_PAYLOAD, 1'b0, w_b, i_st.packet_kind[1:0]);
                            o_nres = 2'd1;
                        end
                        o_st.bytes_remaining = w_rem_dec;
                        if (w_rem_dec == 32'd0) begin
                            o_st.header_position = 3'd0;
                            if (i_st.packet_kind == KIND_EXIT) begin
                                o_st.phase = PH_FINISHED;
                                o_res0     = mk_res(EV_EXITED, 1'b0, 8'd0, 2'd0);
                                o_nres     = 2'd1;
                            end
                        end
                    end else if (i_st.header_position == 3'd0) begin
                        o_st.packet_kind     = w_b;
                        o_st.bytes_remaining = '0;
                        o_st.header_position = w_pos_inc;
                    end else begin
                        o_st.bytes_remaining = w_len;
                        o_st.header_position = w_pos_inc;
                        if (w_pos_inc == HEADER_BYTES) begin
                            if (w_len > {7'd0, i_max_len}) begin
                                o_st.phase           = PH_FINISHED;
                                o_st.header_position = 3'd0;
                                o_res0 = mk_res(EV_BAD_PACKET, 1'b0, 8'd0, 2'd0);
                                o_nres = 2'd1;
                            end else if (w_len == 32'd0) begin
                                // An empty packet completes at its header.
                                o_st.header_position = 3'd0;
                                if (i_st.packet_kind == KIND_EXIT) begin
                                    o_st.phase = PH_FINISHED;
                                    o_res0     = mk_res(EV_EXITED, 1'b0, 8'd0, 2'd0);
                                    o_nres     = 2'd1;
                                end
                            end
                        end
                    end
                end

                default: begin
                    // Connecting and finished drop received bytes.
                end
            endcase
        end

        if (o_nres == 2'd1) begin
            o_res0.last = 1'b1;
        end else if (o_nres == 2'd2) begin
            o_res1.last = 1'b1;
        end
    end

endmodule

// File: rtl/core/shell_session_stream_deframer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shell session stream deframer
// Parses a received byte stream through the session handshake, the failure
// report and the framed or raw streaming phases, and emits result events.
// ----------------------------------------------------------------------------
// Flow: an accepted item is held in the input register until it is processed;
// its results are then registered into the result queue and offered there.
// Throughput: one item per cycle while the queue has room for two results.
// The result port moves one result per cycle while the output is not stalled,
// so the two results of the final byte of a failure message leave one after
// the other. Synchronous active-low reset restores the register defaults,
// the connecting phase and an empty result queue.
// ----------------------------------------------------------------------------
module shell_session_stream_deframer_unit import ssd_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Configuration write port.
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_index,
    input  logic [MAX_LEN_W-1:0] i_cfg_data,
    // Input channel.
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in_item             i_in,
    // Result channel.
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out_item            o_out
);

    // The result queue holds four entries. An item in the input register is
    // processed only when at least two entries are free, which covers the
    // worst case of two results from one item.
    localparam int unsigned QDEPTH = 4;

    // Configuration registers.
    logic                 r_framed;
    logic [MAX_LEN_W-1:0] r_max_len;

    // Input register.
    logic                 r_in_valid;
    t_in_item             r_in;

    // Session state.
    t_state               r_st;

    // Result queue.
    t_out_item            r_q [QDEPTH];
    logic [1:0]           r_wr;
    logic [1:0]           r_rd;
    logic [2:0]           r_count;

    // Step logic outputs.
    t_state               n_st;
    logic                 n_framed;
    t_out_item            w_res0;
    t_out_item            w_res1;
    logic [1:0]           w_nres;

    logic                 w_proc;
    logic                 w_accept;
    logic                 w_pop;
    logic [1:0]           w_push;
    logic [2:0]           n_count;

    // The held item moves on when the queue can take two more results.
    assign w_proc     = r_in_valid && (r_count <= 3'd2);
    assign o_in_stall = r_in_valid && !w_proc;
    assign w_accept   = i_in_valid && !o_in_stall;

    assign o_out_valid = (r_count != 3'd0);
    assign o_out       = r_q[r_rd];
    assign w_pop       = o_out_valid && !i_out_stall;
    assign w_push      = w_proc ? w_nres : 2'd0;
    assign n_count     = r_count + {1'b0, w_push} - {2'b0, w_pop};

    ssd_step u_step (
        .i_item    (r_in),
        .i_st      (r_st),
        .i_framed  (r_framed),
        .i_max_len (r_max_len),
        .o_st      (n_st),
        .o_framed  (n_framed),
        .o_res0    (w_res0),
        .o_res1    (w_res1),
        .o_nres    (w_nres)
    );

    // Control state, configuration and session state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_framed   <= 1'b1;
            r_max_len  <= DEFAULT_MAX_PACKET;
            // The phase is the leading field; everything else clears.
            r_st       <= {PH_CONNECTING, {($bits(t_state) - $bits(t_phase)){1'b0}}};
            r_wr       <= '0;
            r_rd       <= '0;
            r_count    <= '0;
        end else begin
            if (w_accept) begin
                r_in_valid <= 1'b1;
            end else if (w_proc) begin
                r_in_valid <= 1'b0;
            end

            if (w_proc) begin
                r_st <= n_st;
            end

            // A failure that answers the shell request drops framed mode. The user
            // must write configuration only while the block is idle; the block does not enforce it.
            if (i_cfg_we && i_cfg_index == REG_USE_FRAMED) begin
                r_framed <= i_cfg_data[0];
            end else if (w_proc) begin
                r_framed <= n_framed;
            end
            if (i_cfg_we && i_cfg_index == REG_MAX_PACKET) begin
                r_max_len <= i_cfg_data;
            end

            r_wr    <= r_wr + w_push;
            r_rd    <= r_rd + {1'b0, w_pop};
            r_count <= n_count;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in <= i_in;
        end
        if (w_push != 2'd0) begin
            r_q[r_wr] <= w_res0;
        end
        if (w_push == 2'd2) begin
            r_q[r_wr + 2'd1] <= w_res1;
        end
    end

    // The queue never holds more entries than it has.
    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 3'(QDEPTH))
        else $error("result queue overflow");

    // A held item that is not processed stays in place unchanged.
    a_hold_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_proc) |=> (r_in_valid && $stable(r_in)))
        else $error("held input item lost or changed");

    // An item that makes no result never grows the queue.
    a_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!w_proc || w_nres == 2'd0) |=> (r_count <= $past(r_count)))
        else $error("result queue grew without a result");

    // The session leaves the finished phase only through reset.
    a_finished_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st.phase == PH_FINISHED) |=> (r_st.phase == PH_FINISHED))
        else $error("session left the finished phase");

endmodule
